@@ rtl/core/i2dec_pkg.sv @@
// shared types and constants for the signed integer to decimal text converter
// no dependencies
`timescale 1ns / 1ps

package i2dec_pkg;

	localparam int unsigned VALUE_BITS = 64;
	localparam int unsigned DEF_WIDTH  = 64;
	localparam int unsigned CHAR_BITS  = 6;

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic skip;
		logic sign;
		logic digit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bits_last;
		logic top_zero;
		logic one_left;
		logic neg;
	} sts_t;

endpackage

@@ rtl/core/signed_int64_to_decimal_ascii_core.sv @@
// signed integer to decimal ascii text converter, top level
// Usage:
//   Raise start with an integer on value; the transfer takes place at a rising
//   edge with start high and busy low. Only the low WIDTH bits of value are
//   used, read as two's complement.
//   The text leaves on character, most significant first, one character per
//   cycle marked by strobe: '-' for a negative number, then the digits of the
//   magnitude with leading zeros removed. last is high on the final character.
//   Results cannot be held off; each is valid for exactly one cycle.
// Sequence:
//   A shift-and-add-3 step for each of the WIDTH bits, then dropping the leading
//   zeros, the sign decision and the characters. busy stays high until the final
//   character is shown, and at WIDTH 64 a number has up to NDIG = 19 digits;
//   the next start is taken in the cycle that shows the final character, so a
//   new number is only accepted once the last one has been sent.
// Reset:
//   arst_n clears the controller to idle and the strobe low; no state is kept
//   between numbers.
// depends on i2dec_pkg, i2dec_ctrl, i2dec_dpath
`timescale 1ns / 1ps

module signed_int64_to_decimal_ascii_core #(
	parameter int unsigned WIDTH = i2dec_pkg::DEF_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [i2dec_pkg::VALUE_BITS-1:0] value,
	output logic                             strobe,
	output logic [i2dec_pkg::CHAR_BITS-1:0]  character,
	output logic                             last
);
	import i2dec_pkg::*;

	cmd_t cmd;
	sts_t sts;

	i2dec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	i2dec_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

	// characters only come out of a conversion that was running
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("character transfer without a conversion in progress");

	// an accepted number always occupies the block
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after number transfer");

	// the final character is always a digit
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> (character >= ASCII_ZERO && character <= ASCII_ZERO + 6'd9))
		else $error("final character is not a digit");

	// a sign is never the final character and is followed by a digit
	a_sign_next: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == ASCII_MINUS) |-> (!last ##1 strobe))
		else $error("sign not followed by a digit");

endmodule

@@ rtl/core/i2dec_dpath.sv @@
// datapath: magnitude register, shift-and-add-3 bcd converter, output register
// depends on i2dec_pkg
`timescale 1ns / 1ps

module i2dec_dpath #(
	parameter int unsigned WIDTH = i2dec_pkg::DEF_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [i2dec_pkg::VALUE_BITS-1:0] value,
	input  i2dec_pkg::cmd_t                  cmd,
	output i2dec_pkg::sts_t                  sts,
	output logic [i2dec_pkg::CHAR_BITS-1:0]  character,
	output logic                             last,
	output logic                             strobe
);
	import i2dec_pkg::*;

	// decimal digits of the largest magnitude, 2^(WIDTH-1)
	localparam int unsigned NDIG      = ((WIDTH - 1) * 30103) / 100000 + 1;
	localparam int unsigned BCD_BITS  = 4 * NDIG;
	localparam int unsigned BCNT_BITS = $clog2(WIDTH + 1);
	localparam int unsigned DCNT_BITS = $clog2(NDIG + 1);

	logic [WIDTH-1:0]     mag_q;
	logic                 neg_q;
	logic [BCD_BITS-1:0]  bcd_q;
	logic [BCD_BITS-1:0]  adj_bcd;
	logic [BCNT_BITS-1:0] bit_cnt_q;
	logic [DCNT_BITS-1:0] dig_cnt_q;
	logic [3:0]           top_digit;
	logic [CHAR_BITS-1:0] character_q;
	logic                 last_q;
	logic                 strobe_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj_bcd[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	assign top_digit = bcd_q[BCD_BITS-1 -: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[WIDTH-1];
			mag_q <= value[WIDTH-1] ? WIDTH'(~value[WIDTH-1:0] + 1'b1) : value[WIDTH-1:0];
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bcd_q <= {adj_bcd[BCD_BITS-2:0], mag_q[WIDTH-1]};
			mag_q <= {mag_q[WIDTH-2:0], 1'b0};
		end else if (cmd.skip || cmd.digit) begin
			bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cmd.sign || cmd.digit;
			if (cmd.load) begin
				bit_cnt_q <= BCNT_BITS'(WIDTH);
				dig_cnt_q <= DCNT_BITS'(NDIG);
			end else begin
				if (cmd.shift)
					bit_cnt_q <= bit_cnt_q - 1'b1;
				if (cmd.skip || cmd.digit)
					dig_cnt_q <= dig_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sign) begin
			character_q <= ASCII_MINUS;
			last_q      <= 1'b0;
		end else if (cmd.digit) begin
			character_q <= ASCII_ZERO + {2'b00, top_digit};
			last_q      <= (dig_cnt_q == DCNT_BITS'(1));
		end
	end

	assign sts.bits_last = (bit_cnt_q == BCNT_BITS'(1));
	assign sts.top_zero  = (top_digit == 4'd0);
	assign sts.one_left  = (dig_cnt_q == DCNT_BITS'(1));
	assign sts.neg       = neg_q;

	assign character = character_q;
	assign last      = last_q;
	assign strobe    = strobe_q;

endmodule

@@ rtl/core/i2dec_ctrl.sv @@
// controller: sequences load, conversion, leading zero skip and character output
// depends on i2dec_pkg
`timescale 1ns / 1ps

module i2dec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  i2dec_pkg::sts_t sts,
	output i2dec_pkg::cmd_t cmd,
	output logic            busy
);
	import i2dec_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CONV   = 5'b00010,
		ST_SKIP   = 5'b00100,
		ST_SIGN   = 5'b01000,
		ST_DIGITS = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (sts.bits_last)
					state_d = ST_SKIP;
			end
			ST_SKIP: begin
				// drop leading zeros, but always keep one digit
				if (sts.top_zero && !sts.one_left)
					cmd.skip = 1'b1;
				else if (sts.neg)
					state_d = ST_SIGN;
				else
					state_d = ST_DIGITS;
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = ST_DIGITS;
			end
			ST_DIGITS: begin
				cmd.digit = 1'b1;
				if (sts.one_left)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ sim/i2dec_text_checker.sv @@
// checker for the integer to decimal text converter: watches the start and the
// strobe channels, predicts each number's text and compares it character by character
// depends on i2dec_pkg
`timescale 1ns / 1ps

module i2dec_text_checker #(
	parameter int unsigned WIDTH = i2dec_pkg::DEF_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [i2dec_pkg::VALUE_BITS-1:0] value,
	input  logic                             strobe,
	input  logic [i2dec_pkg::CHAR_BITS-1:0]  character,
	input  logic                             last,
	output int                               fails,
	output int                               pending,
	output int                               numbers,
	output int                               chars
);

	import i2dec_pkg::*;

	typedef struct packed {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} text_char_t;

	text_char_t text_due[$];

	int fail_count   = 0;
	int due_count    = 0;
	int number_total = 0;
	int char_total   = 0;

	assign fails   = fail_count;
	assign pending = due_count;
	assign numbers = number_total;
	assign chars   = char_total;

	task automatic report_mismatch(input string what, input logic [CHAR_BITS-1:0] got,
			input logic [CHAR_BITS-1:0] want);
		$display("%0t ns: mismatch on %s, got %0d, want %0d (number %0d, char %0d)",
			$realtime, what, got, want, number_total, char_total);
		fail_count++;
	endtask

	// queues the text of one number: optional sign, then digits most significant first
	function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] mask;
		logic [VALUE_BITS-1:0] v;
		logic [VALUE_BITS-1:0] mag;
		logic                  neg;
		logic [3:0]            digs [0:23];
		int                    nd;
		int                    total;
		int                    k;
		text_char_t            c;
		mask = {VALUE_BITS{1'b1}} >> (VALUE_BITS - WIDTH);
		v    = raw & mask;
		neg  = v[WIDTH-1];
		// magnitude as unsigned, so the most negative value stays exact
		mag  = neg ? ((~v + 1'b1) & mask) : v;
		nd   = 0;
		do begin
			digs[nd] = 4'(mag % 10);
			mag      = mag / 10;
			nd++;
		end while (mag != 0);
		total = nd + (neg ? 1 : 0);
		k     = 0;
		if (neg) begin
			c.code = ASCII_MINUS;
			c.last = (k + 1 == total);
			text_due.push_back(c);
			k++;
		end
		for (int i = nd - 1; i >= 0; i--) begin
			c.code = ASCII_ZERO + CHAR_BITS'(digs[i]);
			c.last = (k + 1 == total);
			text_due.push_back(c);
			k++;
		end
	endfunction

	always @(posedge clk) begin : watch
		text_char_t want;
		if (arst_n) begin
			if (strobe) begin
				if (text_due.size() == 0) begin
					report_mismatch("character with nothing due", character, '0);
				end else begin
					want = text_due.pop_front();
					if (character !== want.code)
						report_mismatch("character", character, want.code);
					if (last !== want.last)
						report_mismatch("last flag", CHAR_BITS'(last), CHAR_BITS'(want.last));
				end
				char_total++;
			end
			if (start && !busy) begin
				predict_text(value);
				number_total++;
			end
			due_count = text_due.size();
		end
	end

endmodule

@@ sim/tb_signed_int64_to_decimal_ascii_core.sv @@
// testbench top for the integer to decimal text converter: directed and random
// numbers under several sender idle mixes, verdict from the checker's count
// depends on i2dec_pkg, signed_int64_to_decimal_ascii_core, i2dec_text_checker
`timescale 1ns / 1ps

module tb_signed_int64_to_decimal_ascii_core;

	import i2dec_pkg::*;

	localparam int unsigned WIDTH       = DEF_WIDTH;
	localparam int          DRAIN_LIMIT = 5000;
	localparam int          TAIL_CYCLES = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  strobe;
	logic [CHAR_BITS-1:0]  character;
	logic                  last;

	int fails;
	int pending;
	int numbers;
	int chars;

	signed_int64_to_decimal_ascii_core #(.WIDTH(WIDTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	i2dec_text_checker #(.WIDTH(WIDTH)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.fails     (fails),
		.pending   (pending),
		.numbers   (numbers),
		.chars     (chars)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d characters still due", pending);
		$display("Some tests failed");
		$finish;
	end

	// mix of full-range, short, near a power of ten and extreme numbers
	function automatic logic [VALUE_BITS-1:0] rand_value();
		logic [VALUE_BITS-1:0] v;
		logic [VALUE_BITS-1:0] p;
		int                    k;
		case ($urandom_range(0, 4))
			0: v = {$urandom, $urandom};
			1: v = VALUE_BITS'($urandom_range(0, 999));
			2: begin
				p = VALUE_BITS'(1);
				k = $urandom_range(0, 18);
				repeat (k) p = p * 10;
				v = p + VALUE_BITS'($urandom_range(0, 2)) - 1;
			end
			3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: begin
				case ($urandom_range(0, 3))
					0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
					1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
					2: v = '0;
					default: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
				endcase
			end
		endcase
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_number(input logic [VALUE_BITS-1:0] v, input int idle_pct);
		int gap;
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			gap = $urandom_range(1, 100);
			start <= 1'b0;
			value <= {$urandom, $urandom};
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	logic [VALUE_BITS-1:0] directed [$];
	int                    idle_mix [3];
	int                    wait_cycles;

	initial begin
		directed = '{
			64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, 64'd99, -64'd100,
			64'h7fff_ffff_ffff_ffff,
			64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001,
			64'd1_000_000_000_000_000_000,
			-64'd1_000_000_000_000_000_000,
			64'd999_999_999_999_999_999,
			-64'd999_999_999_999_999_999,
			64'd1_234_567_890_123_456_789,
			64'haaaa_aaaa_aaaa_aaaa,
			64'h5555_5555_5555_5555,
			64'd4_294_967_296,
			-64'd4_294_967_295
		};
		idle_mix = '{0, 57, 14};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// back to back, so the next start meets the final character
		foreach (directed[i])
			send_number(directed[i], 0);
		foreach (idle_mix[ph])
			repeat (45) send_number(rand_value(), idle_mix[ph]);
		start <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			wait_cycles++;
		end
		if (pending != 0) begin
			$display("drain timeout with %0d characters still due", pending);
			$display("Some tests failed");
			$finish;
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			$display("converted %0d numbers into %0d characters, %0d directed extremes first",
				numbers, chars, directed.size());
			$display("random part ran back to back, then with the sender idle 57 and 14 percent");
			if (fails == 0)
				$display("All tests passed");
			else
				$display("Some tests failed");
			$finish;
		end
	end

endmodule

@@ signed_int64_to_decimal_ascii_core.f @@
rtl/core/i2dec_pkg.sv
rtl/core/i2dec_dpath.sv
rtl/core/i2dec_ctrl.sv
rtl/core/signed_int64_to_decimal_ascii_core.sv
sim/i2dec_text_checker.sv
sim/tb_signed_int64_to_decimal_ascii_core.sv
